// ----- sv/iacr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iacr_pkg
// Shared types and constants of the input activity change reporter.
// ----------------------------------------------------------------------------
package iacr_pkg;

	localparam int NUM_CHANNELS_DEF = 4;

	localparam int CH_W     = 2;
	localparam int TIME_W   = 32;
	localparam int AXIS_W   = 8;
	localparam int ANGLE_W  = 16;
	localparam int BUTTON_W = 32;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int CFG_W      = 16;

	localparam logic [CFG_W-1:0] TURN_DEADBAND_RST   = 16'd40;
	localparam logic [CFG_W-1:0] MIN_INTERVAL_RST    = 16'd100;
	localparam logic [ANGLE_W:0] HALF_TURN           = 17'h08000;
	localparam logic [ANGLE_W:0] FULL_TURN           = 17'h10000;

	typedef enum logic {
		REG_TURN_DEADBAND = 1'b0,
		REG_MIN_INTERVAL  = 1'b1
	} iacr_reg_t;

	// per-channel record kept in the state memory
	typedef struct packed {
		logic [TIME_W-1:0]   rep_time;
		logic [BUTTON_W-1:0] buttons;
		logic [ANGLE_W-1:0]  pitch;
		logic [ANGLE_W-1:0]  yaw;
		logic                moving;
	} iacr_entry_t;

	localparam int ENTRY_W = $bits(iacr_entry_t);

endpackage

// ----- sv/iacr_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iacr_sample_if
// Sample request channel: valid/ready handshake with one input sample.
// ----------------------------------------------------------------------------
interface iacr_sample_if;

	logic                                 valid;
	logic                                 ready;
	logic        [iacr_pkg::CH_W-1:0]     channel;
	logic        [iacr_pkg::TIME_W-1:0]   time_ms;
	logic signed [iacr_pkg::AXIS_W-1:0]   forward_axis;
	logic signed [iacr_pkg::AXIS_W-1:0]   side_axis;
	logic signed [iacr_pkg::ANGLE_W-1:0]  pitch_angle;
	logic signed [iacr_pkg::ANGLE_W-1:0]  yaw_angle;
	logic        [iacr_pkg::BUTTON_W-1:0] button_bits;

	modport source (
		output valid, channel, time_ms, forward_axis, side_axis, pitch_angle, yaw_angle,
		       button_bits,
		input  ready
	);

	modport sink (
		input  valid, channel, time_ms, forward_axis, side_axis, pitch_angle, yaw_angle,
		       button_bits,
		output ready
	);

endinterface

// ----- sv/iacr_report_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iacr_report_if
// Report request channel: valid/ready handshake with one activity report.
// ----------------------------------------------------------------------------
interface iacr_report_if;

	logic                          valid;
	logic                          ready;
	logic [iacr_pkg::TIME_W-1:0]   report_time;
	logic [iacr_pkg::CH_W-1:0]     report_channel;
	logic [iacr_pkg::BUTTON_W-1:0] report_buttons;
	logic                          is_moving;
	logic                          is_turning;

	modport source (
		output valid, report_time, report_channel, report_buttons, is_moving, is_turning,
		input  ready
	);

	modport sink (
		input  valid, report_time, report_channel, report_buttons, is_moving, is_turning,
		output ready
	);

endinterface

// ----- sv/iacr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iacr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iacr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/input_activity_change_reporter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_activity_change_reporter
// Per-channel activity detector with rate-limited change reports.
// ----------------------------------------------------------------------------
// Takes one sample per clock. A sample is accepted when its channel state is
// read from the state RAM; the registered record is then compared, updated
// and written back, and a report, if any, is loaded into the output
// register. The single read-modify-write stage around the RAM sets this
// rate; a sample to the channel written in the previous cycle is served by
// forwarding. Input stalls only while a report waits in the output register
// and the next sample also produces one. Seen flags live in flip-flops and
// reset to zero, so the RAM needs no clearing pass after reset. Samples for
// channels at or above NUM_CHANNELS are accepted and dropped.
// ----------------------------------------------------------------------------
module input_activity_change_reporter #(
	parameter int NUM_CHANNELS = iacr_pkg::NUM_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	iacr_sample_if.sink                       sample,
	iacr_report_if.source                     report,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [iacr_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [iacr_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [iacr_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	import iacr_pkg::*;

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	function automatic logic [ANGLE_W:0] angle_gap(input logic [ANGLE_W-1:0] now_a,
	                                                input logic [ANGLE_W-1:0] old_a);
		logic [ANGLE_W-1:0] d;
		d = now_a - old_a;
		angle_gap = ({1'b0, d} > HALF_TURN) ? (FULL_TURN - {1'b0, d}) : {1'b0, d};
	endfunction

	// configuration
	logic [CFG_W-1:0] deadband_q;
	logic [CFG_W-1:0] interval_q;
	logic             cfg_wr;
	iacr_reg_t        cfg_reg;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_reg = iacr_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= TURN_DEADBAND_RST;
			interval_q <= MIN_INTERVAL_RST;
		end else if (cfg_wr) begin
			case (cfg_reg)
				REG_TURN_DEADBAND: deadband_q <= pwdata[CFG_W-1:0];
				REG_MIN_INTERVAL:  interval_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_reg)
			REG_TURN_DEADBAND: prdata = APB_DATA_W'(deadband_q);
			REG_MIN_INTERVAL:  prdata = APB_DATA_W'(interval_q);
			default:           prdata = '0;
		endcase
	end

	// accept stage
	logic          accept;
	logic          in_range;
	logic [AW-1:0] rd_addr;
	logic          advance;

	assign accept   = sample.valid & sample.ready;
	assign in_range = {{(32-CH_W){1'b0}}, sample.channel} < 32'(NUM_CHANNELS);
	assign rd_addr  = AW'(sample.channel);

	logic                valid_s1;
	logic [CH_W-1:0]     chan_s1;
	logic [TIME_W-1:0]   time_s1;
	logic                moving_s1;
	logic [ANGLE_W-1:0]  pitch_s1;
	logic [ANGLE_W-1:0]  yaw_s1;
	logic [BUTTON_W-1:0] buttons_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= in_range;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chan_s1    <= sample.channel;
			time_s1    <= sample.time_ms;
			moving_s1  <= (sample.forward_axis != '0) || (sample.side_axis != '0);
			pitch_s1   <= sample.pitch_angle;
			yaw_s1     <= sample.yaw_angle;
			buttons_s1 <= sample.button_bits;
		end
	end

	// state memory
	logic              wr_en;
	logic [AW-1:0]     addr_s1;
	iacr_entry_t       wr_entry;
	logic [ENTRY_W-1:0] rd_data;

	iacr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_CHANNELS),
		.AW   (AW)
	) u_state_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(wr_entry),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// last write, forwarded to a read that missed it
	logic              wr_valid_s2;
	logic [AW-1:0]     wr_addr_s2;
	iacr_entry_t       wr_data_s2;
	logic [NUM_CHANNELS-1:0] seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_s2 <= 1'b0;
			seen_q      <= '0;
		end else if (wr_en) begin
			wr_valid_s2     <= 1'b1;
			seen_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_addr_s2 <= addr_s1;
			wr_data_s2 <= wr_entry;
		end
	end

	// compare and update
	iacr_entry_t        old_entry;
	logic               seen_s1;
	logic [TIME_W-1:0]  last_time;
	logic [ANGLE_W:0]   pitch_gap;
	logic [ANGLE_W:0]   yaw_gap;
	logic               turning;
	logic               changed;
	logic               due;
	logic               has_report;
	logic               out_load;

	assign addr_s1   = AW'(chan_s1);
	assign old_entry = (wr_valid_s2 && wr_addr_s2 == addr_s1) ? wr_data_s2
	                                                         : iacr_entry_t'(rd_data);
	assign seen_s1   = seen_q[addr_s1];
	assign last_time = seen_s1 ? old_entry.rep_time : '0;
	assign pitch_gap = angle_gap(pitch_s1, old_entry.pitch);
	assign yaw_gap   = angle_gap(yaw_s1, old_entry.yaw);
	assign turning   = seen_s1 && ((pitch_gap > {1'b0, deadband_q}) ||
	                               (yaw_gap > {1'b0, deadband_q}));
	assign changed   = !seen_s1 || (buttons_s1 != old_entry.buttons) ||
	                   (moving_s1 != old_entry.moving) || turning;
	assign due       = (time_s1 - last_time) >= TIME_W'(interval_q);
	assign has_report = changed && due;

	logic out_valid_q;

	assign advance      = !has_report || !out_valid_q || report.ready;
	assign wr_en        = valid_s1 && advance;
	assign out_load     = wr_en && has_report;
	assign sample.ready = !valid_s1 || advance;

	always_comb begin
		wr_entry.rep_time = has_report ? time_s1 : last_time;
		wr_entry.buttons  = buttons_s1;
		wr_entry.pitch    = pitch_s1;
		wr_entry.yaw      = yaw_s1;
		wr_entry.moving   = moving_s1;
	end

	// output register
	logic [TIME_W-1:0]   rep_time_q;
	logic [CH_W-1:0]     rep_chan_q;
	logic [BUTTON_W-1:0] rep_buttons_q;
	logic                rep_moving_q;
	logic                rep_turning_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load | (out_valid_q & ~report.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rep_time_q    <= time_s1;
			rep_chan_q    <= chan_s1;
			rep_buttons_q <= buttons_s1;
			rep_moving_q  <= moving_s1;
			rep_turning_q <= turning;
		end
	end

	assign report.valid          = out_valid_q;
	assign report.report_time    = rep_time_q;
	assign report.report_channel = rep_chan_q;
	assign report.report_buttons = rep_buttons_q;
	assign report.is_moving      = rep_moving_q;
	assign report.is_turning     = rep_turning_q;

	// checks
	a_seen_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid_s2 |-> seen_q[wr_addr_s2])
		else $error("written channel not marked seen");

	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((seen_q & $past(seen_q)) == $past(seen_q)))
		else $error("seen flag cleared");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || report.ready))
		else $error("report overwritten before taken");

	a_report_time_stored: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (wr_data_s2.rep_time == report.report_time))
		else $error("report time not stored as last report time");

	a_turn_needs_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && turning) |-> seen_s1)
		else $error("turn reported on first sample");

endmodule
